>>> design/sapq_pkg.sv
// Shared types and constants for the sorted-array priority queue.
package sapq_pkg;

    localparam int DATA_W    = 32;
    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 2;
    localparam int OCC_W     = 4;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DUMP   = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic                     ins;
        logic                     rem;
        logic                     rot;
        logic signed [DATA_W-1:0] value;
    } cell_ctrl_t;

endpackage

>>> design/sapq_cell.sv
// One storage cell of the sorted chain: holds an entry and its valid flag.
module sapq_cell (
    input  logic                             clk,
    input  logic                             rst_n,
    input  sapq_pkg::cell_ctrl_t             ctrl,
    input  logic signed [sapq_pkg::DATA_W-1:0] head,
    input  logic signed [sapq_pkg::DATA_W-1:0] prev_val,
    input  logic                             prev_ge,
    input  logic                             prev_valid,
    input  logic signed [sapq_pkg::DATA_W-1:0] next_val,
    input  logic                             next_valid,
    output logic signed [sapq_pkg::DATA_W-1:0] val,
    output logic                             valid,
    output logic                             ge
);
    import sapq_pkg::*;

    logic signed [DATA_W-1:0] val_reg;
    logic signed [DATA_W-1:0] val_next;
    logic                     valid_reg;
    logic                     valid_next;

    // empty cells always sit behind the insert point
    assign ge = !valid_reg || (ctrl.value >= val_reg);

    always_comb
    begin
        val_next   = val_reg;
        valid_next = valid_reg;
        if (ctrl.ins)
        begin
            valid_next = valid_reg || prev_valid;
            if (ge)
            begin
                val_next = prev_ge ? prev_val : ctrl.value;
            end
        end
        else if (ctrl.rem)
        begin
            val_next   = next_val;
            valid_next = next_valid;
        end
        else if (ctrl.rot)
        begin
            // the head entry wraps round to the last held cell
            if (next_valid)
            begin
                val_next = next_val;
            end
            else if (valid_reg)
            begin
                val_next = head;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val   = val_reg;
    assign valid = valid_reg;

endmodule

>>> design/sorted_array_priority_queue.sv
// Top level of the descending sorted-array priority queue.
// Entries live in a chain of DEPTH cells, largest at the head. For insert and remove
// requests all cells compare and shift together, so one such request is taken per
// cycle while the result side keeps up. A dump is accepted and then gives one result
// per held entry: the chain rotates one place per result and the head cell feeds the
// output, leaving the order unchanged once all entries have gone past. Requests are
// held off during a dump. Command 3 is taken and dropped without a result.
module sorted_array_priority_queue #(
    parameter int DEPTH = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [sapq_pkg::S_TDATA_W-1:0]     s_tdata,  // cmd[1:0], value[33:2], zero pad
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [sapq_pkg::M_TDATA_W-1:0]     m_tdata,  // data[31:0], occupancy[35:32], pad
    output logic [sapq_pkg::STATUS_W-1:0]      m_tuser,  // status[1:0]
    output logic                               m_tlast
);
    import sapq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic {
        ST_IDLE,
        ST_DUMP
    } state_t;

    state_t                   state_reg;
    state_t                   state_next;
    logic [CW-1:0]            count_reg;
    logic [CW-1:0]            count_next;
    logic [CW-1:0]            dump_left_reg;
    logic [CW-1:0]            dump_left_next;
    logic                     m_tvalid_reg;
    logic                     m_tvalid_next;
    logic [STATUS_W-1:0]      m_tuser_reg;
    logic [STATUS_W-1:0]      m_tuser_next;
    logic                     m_tlast_reg;
    logic                     m_tlast_next;
    logic signed [DATA_W-1:0] m_data_reg;
    logic signed [DATA_W-1:0] m_data_next;
    logic [OCC_W-1:0]         m_occ_reg;
    logic [OCC_W-1:0]         m_occ_next;

    logic                     can_load;
    logic                     accept;
    logic [CMD_W-1:0]         cmd;
    logic                     full;
    logic                     empty;
    cell_ctrl_t               ctrl;

    logic signed [DATA_W-1:0] cell_val [DEPTH];
    logic [DEPTH-1:0]         cell_valid;
    logic [DEPTH-1:0]         cell_ge;

    assign can_load = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && can_load;
    assign accept   = s_tvalid && s_tready;
    assign cmd      = s_tdata[CMD_W-1:0];
    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);

    assign ctrl.ins   = accept && (cmd == CMD_INSERT) && !full;
    assign ctrl.rem   = accept && (cmd == CMD_REMOVE) && !empty;
    assign ctrl.rot   = (state_reg == ST_DUMP) && can_load;
    assign ctrl.value = s_tdata[CMD_W +: DATA_W];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [DATA_W-1:0] pv;
        logic                     pg;
        logic                     pvld;
        logic signed [DATA_W-1:0] nv;
        logic                     nvld;

        if (i == 0)
        begin : g_first
            assign pv   = '0;
            assign pg   = 1'b0;
            assign pvld = 1'b1;
        end
        else
        begin : g_mid
            assign pv   = cell_val[i-1];
            assign pg   = cell_ge[i-1];
            assign pvld = cell_valid[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign nv   = '0;
            assign nvld = 1'b0;
        end
        else
        begin : g_body
            assign nv   = cell_val[i+1];
            assign nvld = cell_valid[i+1];
        end

        sapq_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .head       (cell_val[0]),
            .prev_val   (pv),
            .prev_ge    (pg),
            .prev_valid (pvld),
            .next_val   (nv),
            .next_valid (nvld),
            .val        (cell_val[i]),
            .valid      (cell_valid[i]),
            .ge         (cell_ge[i])
        );
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        dump_left_next = dump_left_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_tuser_next   = m_tuser_reg;
        m_tlast_next   = m_tlast_reg;
        m_data_next    = m_data_reg;
        m_occ_next     = m_occ_reg;

        if (can_load)
        begin
            m_tvalid_next = 1'b0;
            if (accept)
            begin
                case (cmd)
                    CMD_INSERT:
                    begin
                        m_tvalid_next = 1'b1;
                        m_tlast_next  = 1'b1;
                        m_data_next   = '0;
                        if (full)
                        begin
                            m_tuser_next = STATUS_FULL;
                            m_occ_next   = OCC_W'(count_reg);
                        end
                        else
                        begin
                            m_tuser_next = STATUS_OK;
                            count_next   = count_reg + 1'b1;
                            m_occ_next   = OCC_W'(count_reg + 1'b1);
                        end
                    end
                    CMD_REMOVE:
                    begin
                        m_tvalid_next = 1'b1;
                        m_tlast_next  = 1'b1;
                        if (empty)
                        begin
                            m_tuser_next = STATUS_EMPTY;
                            m_data_next  = '0;
                            m_occ_next   = OCC_W'(count_reg);
                        end
                        else
                        begin
                            m_tuser_next = STATUS_OK;
                            m_data_next  = cell_val[0];
                            count_next   = count_reg - 1'b1;
                            m_occ_next   = OCC_W'(count_reg - 1'b1);
                        end
                    end
                    CMD_DUMP:
                    begin
                        if (empty)
                        begin
                            m_tvalid_next = 1'b1;
                            m_tlast_next  = 1'b1;
                            m_tuser_next  = STATUS_EMPTY;
                            m_data_next   = '0;
                            m_occ_next    = OCC_W'(count_reg);
                        end
                        else
                        begin
                            state_next     = ST_DUMP;
                            dump_left_next = count_reg;
                        end
                    end
                    default:
                    begin
                        m_tvalid_next = 1'b0;
                    end
                endcase
            end
            else if (state_reg == ST_DUMP)
            begin
                m_tvalid_next  = 1'b1;
                m_tuser_next   = STATUS_OK;
                m_data_next    = cell_val[0];
                m_occ_next     = OCC_W'(count_reg);
                m_tlast_next   = (dump_left_reg == CW'(1));
                dump_left_next = dump_left_reg - 1'b1;
                if (dump_left_reg == CW'(1))
                begin
                    state_next = ST_IDLE;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            dump_left_reg <= '0;
            m_tvalid_reg  <= 1'b0;
            m_tuser_reg   <= STATUS_OK;
            m_tlast_reg   <= 1'b0;
            m_data_reg    <= '0;
            m_occ_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dump_left_reg <= dump_left_next;
            m_tvalid_reg  <= m_tvalid_next;
            m_tuser_reg   <= m_tuser_next;
            m_tlast_reg   <= m_tlast_next;
            m_data_reg    <= m_data_next;
            m_occ_reg     <= m_occ_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tdata  = {(M_TDATA_W - OCC_W - DATA_W)'(0), m_occ_reg, m_data_reg};

    // the number of valid cells matches the entry count
    a_valid_count : assert property (@(posedge clk) disable iff (!rst_n)
        $countones(cell_valid) == int'(count_reg))
        else $error("valid cells disagree with entry count");

    a_dump_blocks : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DUMP) |-> !s_tready)
        else $error("request taken during dump");

    a_full_status : assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == STATUS_FULL)) |-> full)
        else $error("full status while queue not full");

    a_dump_len : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DUMP) |-> (dump_left_reg != '0) && (dump_left_reg <= count_reg))
        else $error("dump counter out of range");

endmodule

>>> tb/sv/sorted_array_priority_queue_test.sv
// Self-checking testbench for the descending sorted-array priority queue.
module sorted_array_priority_queue_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sapq_pkg::*;

    localparam int DEPTH        = 8;
    localparam int IDLE_LIMIT   = 4000;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_ITEMS = 220;
    localparam int SETTLE       = 2 * DEPTH;
    localparam int REPORT_MAX   = 10;

    // ignored by the block: accepted, no result
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam logic signed [DATA_W-1:0] VALUE_MAX = 32'sh7fff_ffff;
    localparam logic signed [DATA_W-1:0] VALUE_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   data;
        logic                last;
        logic [OCC_W-1:0]    occupancy;
    } outcome_t;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]  m_tuser;
    logic                 m_tlast;

    outcome_t                 awaited[$];
    logic signed [DATA_W-1:0] held[$];
    int                       mismatches  = 0;
    int                       idle_cycles = 0;
    int                       burst_left  = 0;
    int                       rx_cycle    = 0;
    int                       hold_left   = 0;
    bit                       hold_req    = 1'b0;
    outcome_t                 got;
    outcome_t                 want;

    sorted_array_priority_queue #(
        .DEPTH(DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic void push_outcome(logic [STATUS_W-1:0] status,
                                         logic [DATA_W-1:0] data, logic last);
        outcome_t r;
        r.status    = status;
        r.data      = data;
        r.last      = last;
        r.occupancy = OCC_W'(held.size());
        awaited.push_back(r);
    endfunction

    // Applies one accepted request to the queue contents and records its results.
    function automatic void predict_outcome(logic [CMD_W-1:0] cmd,
                                            logic signed [DATA_W-1:0] value);
        int                       pos;
        logic signed [DATA_W-1:0] top;
        case (cmd)
            CMD_INSERT:
            begin
                if (held.size() >= DEPTH)
                begin
                    push_outcome(STATUS_FULL, '0, 1'b1);
                end
                else
                begin
                    pos = held.size();
                    while (pos > 0 && value >= held[pos-1])
                        pos--;
                    held.insert(pos, value);
                    push_outcome(STATUS_OK, '0, 1'b1);
                end
            end
            CMD_REMOVE:
            begin
                if (held.size() == 0)
                begin
                    push_outcome(STATUS_EMPTY, '0, 1'b1);
                end
                else
                begin
                    top = held.pop_front();
                    push_outcome(STATUS_OK, top, 1'b1);
                end
            end
            CMD_DUMP:
            begin
                if (held.size() == 0)
                    push_outcome(STATUS_EMPTY, '0, 1'b1);
                else
                    foreach (held[i])
                        push_outcome(STATUS_OK, held[i], i == held.size() - 1);
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return VALUE_MAX;
            1:       return VALUE_MIN;
            2, 3, 4: return DATA_W'(int'($urandom_range(0, 15)) - 8);
            default: return $urandom();
        endcase
    endfunction

    task automatic send_request(input logic [CMD_W-1:0] cmd,
                                input logic signed [DATA_W-1:0] value);
        int gap;
        if (burst_left == 0)
        begin
            gap        = $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 10);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - CMD_W - DATA_W){1'b0}}, value, cmd};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_outcome(cmd, value);
    endtask

    task automatic wait_for_results();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        while (awaited.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic test_empty_queue();
        send_request(CMD_REMOVE, VALUE_MAX);
        send_request(CMD_DUMP, VALUE_MIN);
        send_request(CMD_UNUSED, 32'sh5a5a_a5a5);
        send_request(CMD_REMOVE, '0);
        wait_for_results();
    endtask

    task automatic test_fill_and_overflow();
        send_request(CMD_INSERT, VALUE_MAX);
        send_request(CMD_INSERT, VALUE_MIN);
        send_request(CMD_INSERT, '0);
        send_request(CMD_INSERT, -1);
        send_request(CMD_INSERT, 1);
        send_request(CMD_INSERT, 5);
        send_request(CMD_INSERT, 5);
        send_request(CMD_UNUSED, VALUE_MIN);
        send_request(CMD_INSERT, 5);
        send_request(CMD_INSERT, 3);
        send_request(CMD_INSERT, VALUE_MAX);
        send_request(CMD_DUMP, '0);
        send_request(CMD_REMOVE, '0);
        send_request(CMD_REMOVE, '0);
        // freed places must take new entries
        send_request(CMD_INSERT, -1);
        send_request(CMD_INSERT, VALUE_MIN);
        send_request(CMD_DUMP, '0);
        repeat (DEPTH + 1)
            send_request(CMD_REMOVE, '0);
        send_request(CMD_DUMP, '0);
        wait_for_results();
    endtask

    // Receiver holds off while requests keep coming, so the block backs up.
    task automatic test_input_stall();
        hold_req = 1'b1;
        repeat (6)
            send_request(CMD_INSERT, pick_value());
        send_request(CMD_DUMP, '0);
        repeat (10)
            send_request(CMD_INSERT, pick_value());
        send_request(CMD_DUMP, '0);
        repeat (4)
            send_request(CMD_REMOVE, '0);
        send_request(CMD_DUMP, '0);
        repeat (6)
            send_request(CMD_REMOVE, '0);
        wait_for_results();
    endtask

    task automatic test_random_traffic();
        int               sent;
        int               tide;
        int               roll;
        int               insert_share;
        logic [CMD_W-1:0] cmd;
        sent = 0;
        tide = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (sent % 24 == 0)
                tide = $urandom_range(0, 2);
            insert_share = (tide == 0) ? 80 : (tide == 1) ? 55 : 30;
            roll = $urandom_range(0, 99);
            if (roll < 3)
                cmd = CMD_UNUSED;
            else if (roll < 13)
                cmd = CMD_DUMP;
            else if (roll < insert_share)
                cmd = CMD_INSERT;
            else
                cmd = CMD_REMOVE;
            send_request(cmd, pick_value());
            if (cmd != CMD_UNUSED)
                sent++;
        end
        wait_for_results();
    endtask

    // Receiver: changing stall pattern, with a long hold-off on request.
    always @(posedge clk)
    begin
        rx_cycle++;
        if (hold_req)
        begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            case ((rx_cycle / 97) % 4)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 1) == 1);
                2:       m_tready <= (rx_cycle % 5 == 0);
                default: m_tready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got.status    = m_tuser;
            got.data      = m_tdata[DATA_W-1:0];
            got.last      = m_tlast;
            got.occupancy = m_tdata[DATA_W+OCC_W-1:DATA_W];
            if (awaited.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected result: status=%0d data=%h last=%0d occ=%0d",
                             got.status, got.data, got.last, got.occupancy);
            end
            else
            begin
                want = awaited.pop_front();
                if (got.status !== want.status || got.data !== want.data ||
                    got.last !== want.last || got.occupancy !== want.occupancy)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("mismatch: status %0d/%0d data %h/%h last %0d/%0d occ %0d/%0d",
                                 want.status, got.status, want.data, got.data,
                                 want.last, got.last, want.occupancy, got.occupancy);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("sorted_array_priority_queue verification failed");
            $finish;
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_queue();
        test_fill_and_overflow();
        test_input_stall();
        test_random_traffic();
        if (mismatches == 0 && awaited.size() == 0)
            $display("sorted_array_priority_queue verification clean");
        else
            $display("sorted_array_priority_queue verification failed");
        $finish;
    end

endmodule

>>> files.f
design/sapq_pkg.sv
design/sapq_cell.sv
design/sorted_array_priority_queue.sv
tb/sv/sorted_array_priority_queue_test.sv
